// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Concurrent property wrappers clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// antecedent implies consequent in the same cycle
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`endif

// File: design/mtbr_pkg.sv
// ----------------------------------------------------------------------------
// mtbr_pkg
// Constants, types and helper functions of the bounded MT19937 generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtbr_pkg;

    localparam int unsigned MT_WORDS  = 624;
    localparam int unsigned MT_SHIFT  = 397;
    localparam int unsigned ADDR_W    = $clog2(MT_WORDS);
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [31:0] MT_MATRIX  = 32'h9908_b0df;
    localparam logic [31:0] MT_HIGH    = 32'h8000_0000;
    localparam logic [31:0] MT_LOW     = 32'h7fff_ffff;
    localparam logic [31:0] MT_TEMP_B  = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMP_C  = 32'hefc6_0000;
    localparam logic [31:0] MT_MULT    = 32'd1812433253;
    localparam logic [31:0] MT_DEFSEED = 32'd5489;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MT_WORDS - 1);
    localparam logic [ADDR_W-1:0] SHIFT_A   = ADDR_W'(MT_SHIFT);
    localparam logic [ADDR_W-1:0] WORDS_A   = ADDR_W'(MT_WORDS);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SEED,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic take;       // latch request word
        logic load;       // write seed into word 0
        logic seed_step;  // one init recurrence step
        logic rd;         // two-word twist read (not used by the datapath)
        logic wb;         // twist one word, write back, temper
        logic mul;        // x * range
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic seed_last;
        logic ge_range;   // low product half >= range
        logic lt_thr;     // low product half < threshold
        logic div_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [31:0] mt_mix(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] far);
        logic [31:0] y;
        y = (a & MT_HIGH) | (b & MT_LOW);
        return far ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    endfunction

    function automatic logic [31:0] mt_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & MT_TEMP_B);
        y = y ^ ((y << 15) & MT_TEMP_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic [31:0] mt_seed_next(input logic [31:0] p,
                                                 input logic [ADDR_W-1:0] i);
        logic [31:0] m;
        m = MT_MULT * (p ^ (p >> 30));
        return m + 32'(i);
    endfunction

endpackage

// File: design/mtbr_ifs.sv
// ----------------------------------------------------------------------------
// mtbr_ifs
// Valid/ready channels: request, result and seed write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtbr_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] range;
    modport source (output valid, output mode, output range, input ready);
    modport sink   (input valid, input mode, input range, output ready);
endinterface

interface mtbr_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface mtbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/mtbr_ram.sv
// ----------------------------------------------------------------------------
// mtbr_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtbr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// File: design/mtbr_datapath.sv
// ----------------------------------------------------------------------------
// mtbr_datapath
// State RAM, seeding, lazy twist, tempering, multiply and threshold divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtbr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtbr_pkg::t_dp_cmd i_cmd,
    output mtbr_pkg::t_dp_sts o_sts,
    input  logic              i_cfg_wr,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_mode,
    input  logic [31:0]       i_range,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_out_value
);
    import mtbr_pkg::*;

    logic [31:0]       r_seed;
    logic [31:0]       r_prev;
    logic [31:0]       r_cur;
    logic [ADDR_W-1:0] r_sidx;
    logic [ADDR_W-1:0] r_widx;
    logic              r_mode;
    logic [31:0]       r_range;
    logic [31:0]       r_x;
    logic [63:0]       r_prod;
    logic [31:0]       r_rem;
    logic [31:0]       r_num;
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    logic [31:0]       r_out_value;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
    logic [31:0]       rdata_a;
    logic [31:0]       rdata_b;
    logic [ADDR_W-1:0] far_sum;
    logic [31:0]       seed_word;
    logic [31:0]       twisted;
    logic [32:0]       rem_sh;
    logic [32:0]       rem_sub;

    assign seed_word = mt_seed_next(r_prev, r_sidx);
    assign twisted   = mt_mix(r_cur, rdata_a, rdata_b);
    assign far_sum   = r_widx + SHIFT_A;
    assign raddr_a   = (r_widx == LAST_ADDR) ? '0 : r_widx + ADDR_W'(1);
    assign raddr_b   = (far_sum >= WORDS_A) ? far_sum - WORDS_A : far_sum;

    always_comb begin
        we    = 1'b0;
        waddr = r_widx;
        wdata = twisted;
        if (i_cmd.load) begin
            we    = 1'b1;
            waddr = '0;
            wdata = r_seed;
        end else if (i_cmd.seed_step) begin
            we    = 1'b1;
            waddr = r_sidx;
            wdata = seed_word;
        end else if (i_cmd.wb) begin
            we    = 1'b1;
        end
    end

    mtbr_ram #(.WIDTH(32), .DEPTH(MT_WORDS)) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign rem_sh  = {r_rem, r_num[31]};
    assign rem_sub = rem_sh - {1'b0, r_range};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= MT_DEFSEED;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prev <= r_seed;
            r_cur  <= r_seed;
            r_sidx <= ADDR_W'(1);
            r_widx <= '0;
        end
        if (i_cmd.seed_step) begin
            r_prev <= seed_word;
            r_sidx <= r_sidx + ADDR_W'(1);
        end
        if (i_cmd.take) begin
            r_mode  <= i_mode;
            r_range <= i_range;
        end
        if (i_cmd.wb) begin
            r_cur  <= rdata_a;
            r_x    <= mt_temper(twisted);
            r_widx <= raddr_a;
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(r_x) * 64'(r_range);
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_num  <= 32'd0 - r_range;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_sub[32] ? rem_sh[31:0] : rem_sub[31:0];
            r_num  <= r_num << 1;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_mode ? r_prod[63:32] : r_x;
        end
    end

    assign o_sts.mode      = r_mode;
    assign o_sts.seed_last = (r_sidx == LAST_ADDR);
    assign o_sts.ge_range  = (r_prod[31:0] >= r_range);
    assign o_sts.lt_thr    = (r_prod[31:0] < r_rem);
    assign o_sts.div_last  = (r_dcnt == DCNT_LAST);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;

endmodule

// File: design/mtbr_ctrl.sv
// ----------------------------------------------------------------------------
// mtbr_ctrl
// Sequencer: seeding, draw, bounded check, threshold division, result load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtbr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mtbr_pkg::t_dp_sts i_sts,
    output mtbr_pkg::t_dp_cmd o_cmd
);
    import mtbr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_thr_ok;
    logic   n_thr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_thr_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_thr_ok <= n_thr_ok;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_thr_ok = r_thr_ok;
        unique case (r_state)
            ST_LOAD:  n_state = ST_SEED;
            ST_SEED: begin
                if (i_sts.seed_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state  = ST_READ;
                    n_thr_ok = 1'b0;
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = i_sts.mode ? ST_MUL : ST_FIN;
            ST_MUL:   n_state = ST_CHECK;
            ST_CHECK: begin
                priority if (i_sts.ge_range) n_state = ST_FIN;
                else if (!r_thr_ok)          n_state = ST_DIV;
                else if (i_sts.lt_thr)       n_state = ST_READ;
                else                         n_state = ST_FIN;
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state  = ST_CHECK;
                    n_thr_ok = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_LOAD;
        endcase
        if (i_cfg_wr) begin
            n_state = ST_LOAD;
        end
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_LOAD:  o_cmd.load      = 1'b1;
            ST_SEED:  o_cmd.seed_step = 1'b1;
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            ST_READ:  o_cmd.rd        = 1'b1;
            ST_WRITE: o_cmd.wb        = 1'b1;
            ST_MUL:   o_cmd.mul       = 1'b1;
            ST_CHECK: o_cmd.div_start = !i_sts.ge_range && !r_thr_ok;
            ST_DIV:   o_cmd.div_step  = 1'b1;
            ST_FIN:   o_cmd.out_load  = i_sts.out_free;
            default:  o_cmd           = '0;
        endcase
    end

endmodule

// File: design/mt19937_bounded_random_top.sv
// Raw word: accepted in IDLE, then READ, WRITE (twist) and FIN (result register load).
// Bounded word: each draw adds MUL (multiply) and CHECK; a rejected draw goes back to READ.
// First rejection candidate of a request runs the 32-step modulo (DIV), then a second check.
// One request in flight: a request is taken only in IDLE, once the last one is finished;
// the next is taken while a finished word waits at the output.
// Reset (sync, active low) and any seed write run the seeding pass (LOAD, then SEED), no requests taken.
// ----------------------------------------------------------------------------
// mt19937_bounded_random_top
// MT19937 generator with raw and unbiased bounded (multiply-and-reject) output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt19937_bounded_random_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mtbr_req_if.sink        i_req,
    mtbr_res_if.source      o_res,
    mtbr_cfg_if.sink        i_cfg
);
    import mtbr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_wr;

    // Seed writes are always taken; they restart the seeding pass.
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    // Controller: sequences seeding, the per-word twist (done lazily, one word
    // per draw, which matches a whole-vector twist word for word), tempering,
    // the multiply, the threshold modulo and the rejection loop.
    mtbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: 624-word state RAM with two read ports, the seed register,
    // the 32x32 multiplier, the restoring divider and the result register.
    mtbr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_data  (i_cfg.data),
        .i_mode      (i_req.mode),
        .i_range     (i_req.range),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_value (o_res.value)
    );

endmodule

// File: design/mtbr_checker.sv
// ----------------------------------------------------------------------------
// mtbr_checker
// Port-level checks of the bounded MT19937 top, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtbr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_value,
    input logic        i_cfg_valid,
    input logic        i_cfg_ready
);

    `ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_value))
    `ASSERT_NEXT(a_cfg_reseed, i_cfg_valid && i_cfg_ready, !i_req_ready)
    `ASSERT_NEXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready)

endmodule

bind mt19937_bounded_random_top mtbr_checker u_mtbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_value (o_res.value),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

// File: tb/mt19937_bounded_random_top_test.sv
// ----------------------------------------------------------------------------
// mt19937_bounded_random_top_test
// Drives raw and bounded requests and seed writes into the generator, keeps a
// software copy of the twister state, and checks every returned word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt19937_bounded_random_top_test;
    import mtbr_pkg::*;

    localparam int MT_N          = 624;
    localparam int MT_M          = 397;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_WORDS  = 2000;
    localparam int DRAIN_CYCLES  = 700;

    typedef enum logic {
        MODE_RAW     = 1'b0,
        MODE_BOUNDED = 1'b1
    } t_mode;

    typedef struct {
        t_mode       mode;
        logic [31:0] range;
        bit          has_known;
        logic [31:0] known;
    } t_req_row;

    logic i_clk;
    logic i_rst_n;

    mtbr_req_if req_ch ();
    mtbr_res_if res_ch ();
    mtbr_cfg_if cfg_ch ();

    mt19937_bounded_random_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    // clock: 20 ns period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Twister model: own copy of the state vector and index
    // ------------------------------------------------------------------
    logic [31:0] twister_words [MT_N];
    int unsigned twister_pos;

    // expected words, with an optional typed-in value for directed rows
    logic [31:0] pending_words [$];
    bit          pending_known [$];
    logic [31:0] pending_known_val [$];

    int  mismatch_count = 0;
    bit  recv_hold;       // long receiver hold-off request
    int  idle_cycles = 0;

    function automatic void twister_seed(input logic [31:0] s);
        logic [31:0] p;
        twister_words[0] = s;
        for (int i = 1; i < MT_N; i++) begin
            p = twister_words[i-1];
            twister_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
        end
        twister_pos = MT_N;
    endfunction

    function automatic logic [31:0] twister_draw();
        logic [31:0] y;
        if (twister_pos >= MT_N) begin
            for (int k = 0; k < MT_N; k++) begin
                y = (twister_words[k] & 32'h8000_0000)
                  | (twister_words[(k+1) % MT_N] & 32'h7fff_ffff);
                twister_words[k] = twister_words[(k+MT_M) % MT_N] ^ (y >> 1)
                                 ^ (y[0] ? 32'h9908_b0df : 32'd0);
            end
            twister_pos = 0;
        end
        y = twister_words[twister_pos];
        twister_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Lemire multiply-and-reject; each rejected draw advances the generator
    function automatic logic [31:0] lemire_value(input logic [31:0] range);
        logic [63:0] m;
        logic [31:0] thr;
        m = {32'd0, twister_draw()} * {32'd0, range};
        if (m[31:0] < range) begin
            thr = (32'd0 - range) % range;
            while (m[31:0] < thr)
                m = {32'd0, twister_draw()} * {32'd0, range};
        end
        return m[63:32];
    endfunction

    function automatic logic [31:0] predict_word(input t_mode mode, input logic [31:0] range);
        if (mode == MODE_RAW)
            return twister_draw();
        if (range == 32'd0) begin
            void'(twister_draw());   // range zero still burns one word
            return 32'd0;
        end
        return lemire_value(range);
    endfunction

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    // valid stays up after the handshake; random_burst drops it at the end
    task automatic send_request(input t_mode mode, input logic [31:0] range,
                                input bit has_known, input logic [31:0] known);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;   // stretches without idling
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode  <= mode;
        req_ch.range <= range;
        pending_words.push_back(predict_word(mode, range));
        pending_known.push_back(has_known);
        pending_known_val.push_back(known);
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    // seed write only while idle; seeding pass then runs inside the block
    task automatic write_seed(input logic [31:0] s);
        wait_drained();
        repeat (8) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        twister_seed(s);
    endtask

    task automatic random_burst(input int n);
        t_mode       mode;
        logic [31:0] range;
        for (int i = 0; i < n; i++) begin
            mode = t_mode'($urandom_range(0, 1));
            case ($urandom_range(0, 5))
                0: range = $urandom_range(0, 16);
                1: range = 32'h8000_0000 + $urandom_range(0, 255);  // heavy rejection
                2: range = 32'hffff_ffff - $urandom_range(0, 15);
                3: range = 32'd1 << $urandom_range(0, 31);
                default: range = $urandom();
            endcase
            send_request(mode, range, 1'b0, 32'd0);
        end
        req_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (recv_hold) begin
                res_ch.ready <= 1'b0;
                while (recv_hold) @(posedge i_clk);
            end
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready) && !recv_hold);
            if (res_ch.valid && res_ch.ready) begin
                if (pending_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word %h", res_ch.value);
                end else begin
                    logic [31:0] exp_w;
                    bit          kn;
                    logic [31:0] kv;
                    exp_w = pending_words.pop_front();
                    kn    = pending_known.pop_front();
                    kv    = pending_known_val.pop_front();
                    if (res_ch.value !== exp_w || (kn && res_ch.value !== kv)) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("word mismatch: expected %h (table %h) actual %h",
                                     exp_w, kv, res_ch.value);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no accepted word on any channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[mt19937_bounded_random_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: known first outputs of seed 5489, range edge cases
    // ------------------------------------------------------------------
    t_req_row directed_rows [] = '{
        '{MODE_RAW,     32'd0,          1'b1, 32'd3499211612},
        '{MODE_RAW,     32'hffff_ffff,  1'b1, 32'd581869302},
        '{MODE_BOUNDED, 32'd0,          1'b1, 32'd0},
        '{MODE_BOUNDED, 32'd1,          1'b1, 32'd0},
        '{MODE_BOUNDED, 32'd2,          1'b0, 32'd0},
        '{MODE_BOUNDED, 32'd3,          1'b0, 32'd0},
        '{MODE_BOUNDED, 32'hffff_ffff,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'h8000_0000,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'h8000_0001,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'hc000_0001,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'h5555_5555,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'haaaa_aaaa,  1'b0, 32'd0},
        '{MODE_BOUNDED, 32'd7,          1'b0, 32'd0},
        '{MODE_BOUNDED, 32'd1000,       1'b0, 32'd0},
        '{MODE_RAW,     32'h1234_5678,  1'b0, 32'd0}
    };

    initial begin : stimulus
        int hold_len;
        recv_hold      = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = 1'b0;
        req_ch.range   = 32'd0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = 32'd0;
        i_rst_n        = 1'b0;
        twister_seed(32'd5489);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].range,
                         directed_rows[i].has_known, directed_rows[i].known);
        // rest of the first twist period plus a wrap into the next one
        random_burst(700);

        // receiver holds off while requests keep coming; block back-pressures
        fork
            begin
                recv_hold = 1'b1;
                hold_len  = $urandom_range(200, 400);
                repeat (hold_len) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            random_burst(20);
        join
        wait_drained();   // sender pause until everything is back

        write_seed(32'd0);
        random_burst(300);
        write_seed(32'hffff_ffff);
        send_request(MODE_BOUNDED, 32'd0, 1'b1, 32'd0);
        random_burst(300);
        write_seed($urandom());
        random_burst(RANDOM_WORDS - 1340);
        write_seed(32'd5489);
        send_request(MODE_RAW, 32'd0, 1'b1, 32'd3499211612);
        random_burst(20);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("[mt19937_bounded_random_top] OK");
        else
            $display("[mt19937_bounded_random_top] ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/mtbr_pkg.sv
design/mtbr_ifs.sv
design/mtbr_ram.sv
design/mtbr_datapath.sv
design/mtbr_ctrl.sv
design/mt19937_bounded_random_top.sv
design/mtbr_checker.sv
tb/mt19937_bounded_random_top_test.sv
